@@ rtl/fnvhs_pkg.sv @@
// fnvhs_pkg: shared types, constants and controller/datapath interface structs
// for the fnv-1a hash set insert core. depends on nothing.
`default_nettype none

package fnvhs_pkg;

  // table geometry
  localparam int BUCKETS = 256;
  localparam int WAYS    = 4;
  localparam int ENTRIES = BUCKETS * WAYS;

  // fixed field widths
  localparam int HASH_W   = 32;
  localparam int CNT_W    = 9;
  localparam int BYTE_W   = 8;
  localparam int BOUT_W   = 8;
  localparam int STATUS_W = 2;

  // derived widths
  localparam int BIDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DIV_W     = $clog2(BUCKETS + 1);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DIV_CNT_W = $clog2(HASH_W);

  // fnv-1a constants
  localparam logic [HASH_W-1:0] HASH_SEED  = 32'h0123_4567;
  localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] HASH_START = HASH_SEED ^ HASH_BASIS;

  localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 9'd256;

  // insert status codes
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_present;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] insert_status;
    logic [HASH_W-1:0]   string_hash;
    logic [BOUT_W-1:0]   bucket_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                hash_byte;
    logic                hash_last;
    logic                div_step;
    logic                look;
    logic                cmp;
    logic                write;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic hit;
    logic way_last;
    logic free_any;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/fnv_hash_set_insert_core.sv @@
// fnv_hash_set_insert_core: top level of the fnv-1a hash set insert block.
// depends on fnvhs_pkg, fnvhs_ctrl, fnvhs_dp (and fnvhs_ram through it).
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in_     | input     | in_valid / in_stall  | in_item_t: byte, present, last
//  out_    | output    | out_valid / out_stall| out_item_t: status, hash, bucket
//  cfg_    | input     | cfg_valid / cfg_ready| bucket_count, 9 bits
//
// a byte item that does not end a string is taken in idle; bytes stream back to back
// an item with last_byte set is accepted, then runs the bit-serial remainder unit,
// one table read, way compares on the single hash ram read port up to a hit or
// the last way, a write when no way hit and one is free, and the result load
// reset is synchronous and active low; it clears all bucket valid flags at once,
// so no clearing pass is needed and items are taken right after reset
// in_stall is high while a string finishes; a waiting result does not block bytes,
// only the load of the next result waits for out_stall to drop
`default_nettype none

module fnv_hash_set_insert_core import fnvhs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input items
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  // result items
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  // bucket count register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // user must write registers only while idle, unenforced; port is always ready
  assign cfg_ready = 1'b1;

  // sequencer: accept, divide, look up, compare ways, write, load result
  fnvhs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_byte),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hash fold, remainder, bucket tables and result register
  fnvhs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // an accepted string end always moves the sequencer out of idle, so in_stall rises
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_byte) |=> in_stall)
    else $error("no stall after string end");

endmodule

`default_nettype wire

@@ rtl/fnvhs_ram.sv @@
// fnvhs_ram: generic simple dual-port ram, one write port, one registered read port.
// no dependencies.
`default_nettype none

module fnvhs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fnvhs_ctrl.sv @@
// fnvhs_ctrl: sequencer for the insert core, drives datapath commands.
// depends on fnvhs_pkg.
`default_nettype none

module fnvhs_ctrl import fnvhs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_last,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOOK,
    S_CMP,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_last) begin
            cmd.hash_last = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            cmd.hash_byte = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        priority if (sts.hit) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_PRESENT;
          state_nxt       = S_DONE;
        end else if (sts.way_last && sts.free_any) begin
          state_nxt = S_WRITE;
        end else if (sts.way_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_FULL;
          state_nxt       = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_WRITE: begin
        cmd.write       = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = ST_ADDED;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fnvhs_dp.sv @@
// fnvhs_dp: hash, bit-serial remainder, way search, tables and output register.
// depends on fnvhs_pkg and fnvhs_ram.
`default_nettype none

module fnvhs_dp import fnvhs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_item_t       out_data
);

  logic [CNT_W-1:0]     bucket_count_r;
  logic [HASH_W-1:0]    run_hash_r;
  logic [HASH_W-1:0]    fin_hash_r;
  logic [HASH_W-1:0]    div_sh_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     divisor_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [WAY_W-1:0]     way_r;
  logic [WAY_W-1:0]     free_way_r;
  logic                 free_found_r;
  logic                 rowv_r;
  logic [BUCKETS-1:0]   row_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // byte fold
  logic [HASH_W-1:0]   mixed;
  logic [HASH_W-1:0]   prod;
  logic [HASH_W-1:0]   hash_in;

  assign mixed   = run_hash_r ^ HASH_W'(in_data.data_byte);
  assign prod    = mixed * HASH_PRIME;
  assign hash_in = in_data.byte_present ? prod[HASH_W-1:0] : run_hash_r;

  // buckets in use: zero means one, clamp to table size
  logic [31:0]      bc32;
  logic [31:0]      eff32;
  logic [DIV_W-1:0] divisor;

  assign bc32    = 32'(bucket_count_r);
  assign eff32   = (bc32 == 32'd0) ? 32'd1 :
                   (bc32 > 32'(BUCKETS)) ? 32'(BUCKETS) : bc32;
  assign divisor = eff32[DIV_W-1:0];

  // one remainder bit per cycle
  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_diff;
  logic [DIV_W-1:0] rem_nxt;

  assign rem_sh   = {rem_r, div_sh_r[HASH_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor_r};
  assign rem_nxt  = !rem_diff[DIV_W] ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];

  logic [BIDX_W-1:0] bucket;
  assign bucket = rem_r[BIDX_W-1:0];

  // table addressing
  logic [31:0]      base32;
  logic [31:0]      rd_way32;
  logic [31:0]      rd_addr32;
  logic [31:0]      wr_addr32;
  logic             rd_en;
  logic [HASH_W-1:0] hash_q;
  logic [WAYS-1:0]   vram_q;
  logic [WAYS-1:0]   vrow;
  logic [WAYS-1:0]   vrow_wdata;
  logic              way_bit;
  logic              way_last;

  assign base32    = 32'(bucket) * 32'(WAYS);
  assign rd_way32  = cmd.look ? 32'd0 : (32'(way_r) + 32'd1);
  assign rd_addr32 = base32 + rd_way32;
  assign wr_addr32 = base32 + 32'(free_way_r);
  assign rd_en     = cmd.look || (cmd.cmp && !way_last);

  assign vrow       = rowv_r ? vram_q : '0;
  assign way_bit    = vrow[way_r];
  assign way_last   = (way_r == WAY_W'(WAYS - 1));
  assign vrow_wdata = vrow | (WAYS'(1) << free_way_r);

  fnvhs_ram #(
    .WIDTH (HASH_W),
    .DEPTH (ENTRIES)
  ) u_hash_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wr_addr32[ENT_W-1:0]),
    .wdata (fin_hash_r),
    .re    (rd_en),
    .raddr (rd_addr32[ENT_W-1:0]),
    .rdata (hash_q)
  );

  fnvhs_ram #(
    .WIDTH (WAYS),
    .DEPTH (BUCKETS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (bucket),
    .wdata (vrow_wdata),
    .re    (cmd.look),
    .raddr (bucket),
    .rdata (vram_q)
  );

  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(HASH_W - 1));
  assign sts.hit      = way_bit && (hash_q == fin_hash_r);
  assign sts.way_last = way_last;
  assign sts.free_any = free_found_r || !way_bit;
  assign sts.out_busy = out_valid_r && out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RESET;
      run_hash_r     <= HASH_START;
      row_valid_r    <= '0;
      out_valid_r    <= 1'b0;
      free_found_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count_r <= cfg_data;
      end
      if (cmd.hash_byte) begin
        run_hash_r <= hash_in;
      end else if (cmd.hash_last) begin
        run_hash_r <= HASH_START;
      end
      if (cmd.write) begin
        row_valid_r[bucket] <= 1'b1;
      end
      if (cmd.look) begin
        free_found_r <= 1'b0;
      end else if (cmd.cmp && !way_bit) begin
        free_found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.hash_last) begin
      fin_hash_r <= hash_in;
      div_sh_r   <= hash_in;
      rem_r      <= '0;
      div_cnt_r  <= '0;
      divisor_r  <= divisor;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      div_sh_r  <= {div_sh_r[HASH_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.look) begin
      way_r  <= '0;
      rowv_r <= row_valid_r[bucket];
    end
    if (cmd.cmp) begin
      if (!free_found_r && !way_bit) begin
        free_way_r <= way_r;
      end
      way_r <= way_r + 1'b1;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.out_load) begin
      out_data_r.insert_status <= status_r;
      out_data_r.string_hash   <= fin_hash_r;
      out_data_r.bucket_index  <= BOUT_W'(32'(bucket));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the remainder stays below the divisor throughout the division
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < divisor_r))
    else $error("remainder not below divisor during division");

  // a table write needs a free way found by the search
  a_write_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> free_found_r)
    else $error("table write without a free way");

  // loading the result never overwrites an item still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  // the loaded result carries the finished hash
  a_out_hash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_data_r.string_hash == $past(fin_hash_r)))
    else $error("result hash differs from finished hash");

endmodule

`default_nettype wire
